@@ hdl/eisu_pkg.sv @@
`default_nettype none

package eisu_pkg;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_ACK   = 2'd3
    } t_kind;

    localparam logic [7:0] ADDR_SENSE = 8'h69;
    localparam logic [7:0] ADDR_FLAGS = 8'h3C;
    localparam logic [7:0] ADDR_MASK  = 8'h3D;

    localparam logic [1:0] ACK_INT0 = 2'd1;
    localparam logic [1:0] ACK_INT1 = 2'd2;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] address;
        logic [7:0] write_data;
        logic       pin_int0;
        logic       pin_int1;
        logic       global_enable;
        logic [1:0] ack_vector;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       flag_int0;
        logic       flag_int1;
        logic       request_int0;
        logic       request_int1;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/eisu_core.sv @@
`default_nettype none

module eisu_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire eisu_pkg::t_item  i_item,
    output eisu_pkg::t_result     o_result
);

    typedef enum logic [1:0] {
        SENSE_LOW  = 2'd0,
        SENSE_ANY  = 2'd1,
        SENSE_FALL = 2'd2,
        SENSE_RISE = 2'd3
    } t_sense;

    logic [3:0] r_sense;
    logic [1:0] r_mask;
    logic [1:0] r_flags;
    logic [1:0] r_last;
    logic [3:0] n_sense;
    logic [1:0] n_mask;
    logic [1:0] n_flags;
    logic [1:0] n_last;
    logic [1:0] pins;
    logic [1:0] hits;
    logic [7:0] rd;
    logic [1:0] req;

    function automatic logic fires(input t_sense mode, input logic pin, input logic prev);
        logic hit;
        unique case (mode)
            SENSE_LOW:  hit = !pin;
            SENSE_ANY:  hit = pin != prev;
            SENSE_FALL: hit = !pin && prev;
            SENSE_RISE: hit = pin && !prev;
            default:    hit = 1'b0;
        endcase
        return hit;
    endfunction

    assign pins = {i_item.pin_int1, i_item.pin_int0};
    assign hits[0] = r_mask[0] && fires(t_sense'(r_sense[1:0]), pins[0], r_last[0]);
    assign hits[1] = r_mask[1] && fires(t_sense'(r_sense[3:2]), pins[1], r_last[1]);

    always_comb begin
        n_sense = r_sense;
        n_mask  = r_mask;
        n_flags = r_flags;
        n_last  = r_last;
        rd      = 8'd0;
        req     = 2'b00;
        unique case (i_item.kind)
            eisu_pkg::KIND_TICK: begin
                n_flags = r_flags | hits;
                n_last  = pins;
                if (i_item.global_enable) begin
                    req = n_flags;
                end
            end
            eisu_pkg::KIND_WRITE: begin
                priority if (i_item.address == eisu_pkg::ADDR_SENSE) begin
                    n_sense = i_item.write_data[3:0];
                end else if (i_item.address == eisu_pkg::ADDR_FLAGS) begin
                    n_flags = i_item.write_data[1:0];
                end else if (i_item.address == eisu_pkg::ADDR_MASK) begin
                    n_mask = i_item.write_data[1:0];
                end
            end
            eisu_pkg::KIND_READ: begin
                priority if (i_item.address == eisu_pkg::ADDR_SENSE) begin
                    rd = {4'd0, r_sense};
                end else if (i_item.address == eisu_pkg::ADDR_FLAGS) begin
                    rd = {6'd0, r_flags};
                end else if (i_item.address == eisu_pkg::ADDR_MASK) begin
                    rd = {6'd0, r_mask};
                end
            end
            eisu_pkg::KIND_ACK: begin
                if (i_item.ack_vector == eisu_pkg::ACK_INT0) begin
                    n_flags[0] = 1'b0;
                end else if (i_item.ack_vector == eisu_pkg::ACK_INT1) begin
                    n_flags[1] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sense <= 4'd0;
            r_mask  <= 2'd0;
            r_flags <= 2'd0;
            r_last  <= 2'd0;
        end else if (i_fire) begin
            r_sense <= n_sense;
            r_mask  <= n_mask;
            r_flags <= n_flags;
            r_last  <= n_last;
        end
    end

    assign o_result.read_data    = rd;
    assign o_result.flag_int0    = n_flags[0];
    assign o_result.flag_int1    = n_flags[1];
    assign o_result.request_int0 = req[0];
    assign o_result.request_int1 = req[1];

endmodule

`default_nettype wire

@@ hdl/external_interrupt_sense_unit.sv @@
// Channel   Dir  Signals                        Beat contents
// s_axis    in   tvalid tready tdata[23:0] tuser[1:0]   tick, bus access or acknowledge
// m_axis    out  tvalid tready tdata[15:0]              read data, flags, requests
//
// Each beat passes from acceptance through the input register and then the result register,
// with the state update done between them.
// A new beat is accepted every cycle while results are taken; the rate is one per cycle.
// A stalled result holds while one more input beat waits in the input register.
// Reset is synchronous and clears both valid bits and all interrupt state.
`default_nettype none

module external_interrupt_sense_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // address[7:0], write_data[15:8], pin_int0[16], pin_int1[17],
    // global_enable[18], ack_vector[20:19], zero[23:21]
    input  wire logic [23:0] s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data[7:0], flag_int0[8], flag_int1[9], request_int0[10],
    // request_int1[11], zero[15:12]
    output logic [15:0]      m_axis_tdata
);

    logic              r_in_valid;
    eisu_pkg::t_item   r_item;
    logic              r_out_valid;
    eisu_pkg::t_result r_result;
    eisu_pkg::t_result result;
    logic              advance;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.kind          <= eisu_pkg::t_kind'(s_axis_tuser);
            r_item.address       <= s_axis_tdata[7:0];
            r_item.write_data    <= s_axis_tdata[15:8];
            r_item.pin_int0      <= s_axis_tdata[16];
            r_item.pin_int1      <= s_axis_tdata[17];
            r_item.global_enable <= s_axis_tdata[18];
            r_item.ack_vector    <= s_axis_tdata[20:19];
        end
    end

    eisu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (r_in_valid && advance),
        .i_item   (r_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (advance && r_in_valid) begin
            r_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_result.request_int1, r_result.request_int0,
                            r_result.flag_int1, r_result.flag_int0, r_result.read_data};

endmodule

`default_nettype wire

@@ hdl/eisu_chk.sv @@
`default_nettype none

module eisu_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result beat changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("Result valid after reset.");

    a_request_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[10] || m_axis_tdata[8])
                       && (!m_axis_tdata[11] || m_axis_tdata[9]))
        else $error("Request raised without its flag.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input stalled with an empty result register.");

    a_unused_bits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0 && m_axis_tdata[7:4] == 4'd0)
        else $error("Result beat carries bits beyond the register widths.");

endmodule

bind external_interrupt_sense_unit eisu_chk u_eisu_chk (.*);

`default_nettype wire
